[rtl/assert_macros.svh]
// shared assertion macros, sampled on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge
`define ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

[rtl/ll1ep_pkg.sv]
`default_nettype none

package ll1ep_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  typedef logic [3:0] sym_t;
  typedef logic [2:0] col_t;
  typedef logic [2:0] prod_t;
  typedef logic [2:0] status_t;
  typedef logic [1:0] phase_t;

  // terminals equal their column, nonterminals have bit 3 set
  localparam sym_t SYM_I    = 4'd0;
  localparam sym_t SYM_PLUS = 4'd1;
  localparam sym_t SYM_STAR = 4'd2;
  localparam sym_t SYM_LP   = 4'd3;
  localparam sym_t SYM_RP   = 4'd4;
  localparam sym_t SYM_END  = 4'd5;
  localparam sym_t SYM_E    = 4'd8;
  localparam sym_t SYM_R    = 4'd9;
  localparam sym_t SYM_T    = 4'd10;
  localparam sym_t SYM_Y    = 4'd11;
  localparam sym_t SYM_F    = 4'd12;

  localparam col_t COL_I    = 3'd0;
  localparam col_t COL_PLUS = 3'd1;
  localparam col_t COL_STAR = 3'd2;
  localparam col_t COL_LP   = 3'd3;
  localparam col_t COL_RP   = 3'd4;
  localparam col_t COL_END  = 3'd5;
  localparam col_t COL_BAD  = 3'd6;

  // productions
  localparam prod_t P_E_TR   = 3'd0;
  localparam prod_t P_R_PTR  = 3'd1;
  localparam prod_t P_R_EPS  = 3'd2;
  localparam prod_t P_T_FY   = 3'd3;
  localparam prod_t P_Y_SFY  = 3'd4;
  localparam prod_t P_Y_EPS  = 3'd5;
  localparam prod_t P_F_PAR  = 3'd6;
  localparam prod_t P_F_I    = 3'd7;

  localparam status_t ST_OK       = 3'd0;
  localparam status_t ST_ACCEPT   = 3'd1;
  localparam status_t ST_MISMATCH = 3'd2;
  localparam status_t ST_NO_ENTRY = 3'd3;
  localparam status_t ST_OVERFLOW = 3'd4;
  localparam status_t ST_FINISHED = 3'd5;

  localparam phase_t PH_PARSING  = 2'd0;
  localparam phase_t PH_ACCEPTED = 2'd1;
  localparam phase_t PH_REJECTED = 2'd2;

  function automatic col_t column_of(input logic [7:0] c);
    col_t r;
    case (c)
      8'h69:   r = COL_I;     // i
      8'h2b:   r = COL_PLUS;  // +
      8'h2a:   r = COL_STAR;  // *
      8'h28:   r = COL_LP;    // (
      8'h29:   r = COL_RP;    // )
      8'h24:   r = COL_END;   // $
      default: r = COL_BAD;
    endcase
    return r;
  endfunction

  // parse table: {hit, production}
  function automatic logic [3:0] table_lookup(input sym_t nt, input col_t col);
    logic [3:0] r;
    r = 4'd0;
    case (nt)
      SYM_E: begin
        if (col == COL_I || col == COL_LP) r = {1'b1, P_E_TR};
      end
      SYM_R: begin
        if (col == COL_PLUS) r = {1'b1, P_R_PTR};
        else if (col == COL_RP || col == COL_END) r = {1'b1, P_R_EPS};
      end
      SYM_T: begin
        if (col == COL_I || col == COL_LP) r = {1'b1, P_T_FY};
      end
      SYM_Y: begin
        if (col == COL_STAR) r = {1'b1, P_Y_SFY};
        else if (col == COL_PLUS || col == COL_RP || col == COL_END) r = {1'b1, P_Y_EPS};
      end
      SYM_F: begin
        if (col == COL_I) r = {1'b1, P_F_I};
        else if (col == COL_LP) r = {1'b1, P_F_PAR};
      end
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [1:0] prod_len(input prod_t p);
    logic [1:0] r;
    case (p)
      P_E_TR, P_T_FY:             r = 2'd2;
      P_R_PTR, P_Y_SFY, P_F_PAR:  r = 2'd3;
      P_F_I:                      r = 2'd1;
      default:                    r = 2'd0;
    endcase
    return r;
  endfunction

  // right-hand side symbol k, leftmost first
  function automatic sym_t prod_rhs(input prod_t p, input logic [1:0] k);
    sym_t r;
    r = SYM_I;
    case (p)
      P_E_TR:  r = (k == 2'd0) ? SYM_T : SYM_R;
      P_R_PTR: r = (k == 2'd0) ? SYM_PLUS : ((k == 2'd1) ? SYM_T : SYM_R);
      P_T_FY:  r = (k == 2'd0) ? SYM_F : SYM_Y;
      P_Y_SFY: r = (k == 2'd0) ? SYM_STAR : ((k == 2'd1) ? SYM_F : SYM_Y);
      P_F_PAR: r = (k == 2'd0) ? SYM_LP : ((k == 2'd1) ? SYM_E : SYM_RP);
      P_F_I:   r = SYM_I;
      default: r = SYM_I;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[rtl/ll1_expression_parser_top.sv]
// channel   direction  handshake            payload
// in_       slave      in_tvalid/in_tready  tuser: action, tdata: char_code
// out_      master     out_tvalid/out_tready tdata: status, depth
//
// one transaction in flight at a time; in_tready is high only while the parser is idle
// start or finished-parse transaction: idle goes straight to emit and the output register
// character: accepted in idle, then per expansion eval (1 or 2 symbols), eval and wr2
//   (3 symbols), eval and fetch (epsilon), a terminal match eval and fetch, then emit
//   loads the output register; the total is set by the expansion chain and the single
//   write port of the stack memory
// reset loads the stack with $ E; position 0 always holds $ and is never stored
// a result waiting on out_tready does not block the next input transaction; the
//   result of that one then waits in emit until the output register frees
`default_nettype none
`include "assert_macros.svh"

module ll1_expression_parser_top #(
  parameter int STACK_DEPTH = ll1ep_pkg::STACK_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] char_code
  input  wire logic        in_tuser,   // [0] action (0 start, 1 character)
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata   // [2:0] status, [9:3] depth, [15:10] zero
);
  import ll1ep_pkg::*;

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int EW = CW + 1;

  typedef enum logic [2:0] {S_IDLE, S_EVAL, S_WR2, S_FETCH, S_EMIT} state_t;

  // stack below the top entry; the top lives in top_r
  sym_t stack_mem [STACK_DEPTH];
  sym_t rd_data_r;

  state_t          state_r, state_nxt;
  sym_t            top_r, top_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  phase_t          phase_r, phase_nxt;
  col_t            col_r, col_nxt;
  status_t         res_status_r, res_status_nxt;
  logic            pop_r, pop_nxt;          // fetch ends the character
  logic            fetch_zero_r, fetch_zero_nxt;
  logic [AW-1:0]   wr2_addr_r, wr2_addr_nxt;
  sym_t            wr2_sym_r, wr2_sym_nxt;
  logic            out_valid_r, out_valid_nxt;
  status_t         out_status_r, out_status_nxt;
  logic [6:0]      out_depth_r, out_depth_nxt;

  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  sym_t            mem_wd;
  logic [AW-1:0]   mem_ra;

  // decode of the top entry against the current column
  logic [3:0]      lookup;
  prod_t           prod;
  logic [1:0]      plen;
  logic [CW-1:0]   cnt_m1, cnt_m2;
  logic [EW-1:0]   need;
  logic            out_free;

  assign lookup   = table_lookup(top_r, col_r);
  assign prod     = lookup[2:0];
  assign plen     = prod_len(prod);
  assign cnt_m1   = count_r - CW'(1);
  assign cnt_m2   = count_r - CW'(2);
  assign need     = EW'(count_r) - EW'(1) + EW'(plen);
  assign out_free = !out_valid_r || out_tready;

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_depth_r, out_status_r};

  always_comb begin
    state_nxt      = state_r;
    top_nxt        = top_r;
    count_nxt      = count_r;
    phase_nxt      = phase_r;
    col_nxt        = col_r;
    res_status_nxt = res_status_r;
    pop_nxt        = pop_r;
    fetch_zero_nxt = fetch_zero_r;
    wr2_addr_nxt   = wr2_addr_r;
    wr2_sym_nxt    = wr2_sym_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_status_nxt = out_status_r;
    out_depth_nxt  = out_depth_r;
    mem_we         = 1'b0;
    mem_wa         = cnt_m1[AW-1:0];
    mem_wd         = prod_rhs(prod, plen - 2'd1);
    mem_ra         = cnt_m2[AW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (!in_tuser) begin
            top_nxt        = SYM_E;
            count_nxt      = CW'(2);
            phase_nxt      = PH_PARSING;
            res_status_nxt = ST_OK;
            state_nxt      = S_EMIT;
          end else if (phase_r != PH_PARSING) begin
            res_status_nxt = ST_FINISHED;
            state_nxt      = S_EMIT;
          end else begin
            col_nxt   = column_of(in_tdata);
            state_nxt = S_EVAL;
          end
        end
      end
      S_EVAL: begin
        if (count_r == '0) begin
          res_status_nxt = ST_NO_ENTRY;
          phase_nxt      = PH_REJECTED;
          state_nxt      = S_EMIT;
        end else if (top_r == SYM_END) begin
          // acceptance needs the $ character, not just the bottom of the stack
          if (col_r == COL_END) begin
            res_status_nxt = ST_ACCEPT;
            phase_nxt      = PH_ACCEPTED;
          end else begin
            res_status_nxt = ST_MISMATCH;
            phase_nxt      = PH_REJECTED;
          end
          state_nxt = S_EMIT;
        end else if (!top_r[3]) begin
          if (top_r == {1'b0, col_r}) begin
            // consume: pop and fetch the entry below
            count_nxt      = cnt_m1;
            fetch_zero_nxt = (cnt_m2 == '0);
            pop_nxt        = 1'b1;
            state_nxt      = S_FETCH;
          end else begin
            res_status_nxt = ST_MISMATCH;
            phase_nxt      = PH_REJECTED;
            state_nxt      = S_EMIT;
          end
        end else if (!lookup[3]) begin
          // covers invalid characters and codes outside the nonterminals
          res_status_nxt = ST_NO_ENTRY;
          phase_nxt      = PH_REJECTED;
          state_nxt      = S_EMIT;
        end else if (need > EW'(STACK_DEPTH)) begin
          res_status_nxt = ST_OVERFLOW;
          phase_nxt      = PH_REJECTED;
          state_nxt      = S_EMIT;
        end else begin
          count_nxt = need[CW-1:0];
          case (plen)
            2'd0: begin
              fetch_zero_nxt = (cnt_m2 == '0);
              pop_nxt        = 1'b0;
              state_nxt      = S_FETCH;
            end
            2'd1: begin
              top_nxt = prod_rhs(prod, 2'd0);
            end
            2'd2: begin
              mem_we  = 1'b1;
              top_nxt = prod_rhs(prod, 2'd0);
            end
            default: begin
              // rightmost symbol now, middle one next cycle
              mem_we       = 1'b1;
              top_nxt      = prod_rhs(prod, 2'd0);
              wr2_addr_nxt = cnt_m1[AW-1:0] + AW'(1);
              wr2_sym_nxt  = prod_rhs(prod, 2'd1);
              state_nxt    = S_WR2;
            end
          endcase
        end
      end
      S_WR2: begin
        mem_we    = 1'b1;
        mem_wa    = wr2_addr_r;
        mem_wd    = wr2_sym_r;
        state_nxt = S_EVAL;
      end
      S_FETCH: begin
        top_nxt = fetch_zero_r ? SYM_END : rd_data_r;
        if (pop_r) begin
          res_status_nxt = ST_OK;
          state_nxt      = S_EMIT;
        end else begin
          state_nxt = S_EVAL;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = res_status_r;
          out_depth_nxt  = 7'(count_r);
          state_nxt      = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // stack memory with one write and one read port, read data registered; a read that
  // meets a write to the same entry (in S_WR2) is never used, so no forwarding is needed
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= stack_mem[mem_ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      top_r       <= SYM_E;
      count_r     <= CW'(2);
      phase_r     <= PH_PARSING;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      count_r     <= count_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    col_r        <= col_nxt;
    res_status_r <= res_status_nxt;
    pop_r        <= pop_nxt;
    fetch_zero_r <= fetch_zero_nxt;
    wr2_addr_r   <= wr2_addr_nxt;
    wr2_sym_r    <= wr2_sym_nxt;
    out_status_r <= out_status_nxt;
    out_depth_r  <= out_depth_nxt;
  end

  `ASSERT_ALWAYS(a_count_range, (count_r != '0) && (EW'(count_r) <= EW'(STACK_DEPTH)), "stack count out of range")
  `ASSERT_IMPLIES(a_no_write_bottom, mem_we, mem_wa != '0, "write to the end marker slot")
  `ASSERT_IMPLIES(a_accept_top, phase_r == PH_ACCEPTED, top_r == SYM_END, "accepted without end marker on top")
  `ASSERT_IMPLIES(a_out_from_emit, $rose(out_valid_r), $past(state_r) == S_EMIT, "result loaded outside emit")

endmodule

`default_nettype wire

[tb/ll1ep_tb_pkg.sv]
`timescale 1ns / 1ps

package ll1ep_tb_pkg;

  // input transaction kinds carried on in_tuser
  localparam logic ACT_START = 1'b0;
  localparam logic ACT_CHAR  = 1'b1;

  // characters the parser recognizes
  localparam logic [7:0] CH_I    = "i";
  localparam logic [7:0] CH_PLUS = "+";
  localparam logic [7:0] CH_STAR = "*";
  localparam logic [7:0] CH_LP   = "(";
  localparam logic [7:0] CH_RP   = ")";
  localparam logic [7:0] CH_END  = "$";

endpackage

[tb/ll1_result_checker.sv]
`timescale 1ns / 1ps

module ll1_result_checker #(
  parameter int STACK_DEPTH = ll1ep_pkg::STACK_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [15:0] out_tdata,
  output int          fail_count,
  output int          results_outstanding
);
  import ll1ep_pkg::*;
  import ll1ep_tb_pkg::*;

  typedef struct packed {
    status_t    status;
    logic [6:0] depth;
  } parse_result_t;

  sym_t          sym_stack [STACK_DEPTH];
  int unsigned   sym_count;
  phase_t        parse_phase;
  parse_result_t expected_results [$];
  parse_result_t oldest;
  status_t       step_status;

  function automatic void restart_stack();
    sym_stack[0] = SYM_END;
    sym_stack[1] = SYM_E;
    sym_count = 2;
    parse_phase = PH_PARSING;
  endfunction

  function automatic col_t char_column(input logic [7:0] c);
    case (c)
      CH_I:    return COL_I;
      CH_PLUS: return COL_PLUS;
      CH_STAR: return COL_STAR;
      CH_LP:   return COL_LP;
      CH_RP:   return COL_RP;
      CH_END:  return COL_END;
      default: return COL_BAD;
    endcase
  endfunction

  // grammar rule for nonterminal nt under lookahead col, leftmost symbol in s0
  function automatic bit rule_for(input sym_t nt, input col_t col, output int len,
                                  output sym_t s0, output sym_t s1, output sym_t s2);
    bit hit;
    hit = 1'b0;
    len = 0;
    s0 = SYM_I;
    s1 = SYM_I;
    s2 = SYM_I;
    case (nt)
      SYM_E, SYM_T: begin
        if (col == COL_I || col == COL_LP) begin
          hit = 1'b1;
          len = 2;
          s0 = (nt == SYM_E) ? SYM_T : SYM_F;
          s1 = (nt == SYM_E) ? SYM_R : SYM_Y;
        end
      end
      SYM_R: begin
        if (col == COL_PLUS) begin
          hit = 1'b1;
          len = 3;
          s0 = SYM_PLUS;
          s1 = SYM_T;
          s2 = SYM_R;
        end else if (col == COL_RP || col == COL_END) begin
          hit = 1'b1;
        end
      end
      SYM_Y: begin
        if (col == COL_STAR) begin
          hit = 1'b1;
          len = 3;
          s0 = SYM_STAR;
          s1 = SYM_F;
          s2 = SYM_Y;
        end else if (col == COL_PLUS || col == COL_RP || col == COL_END) begin
          hit = 1'b1;
        end
      end
      SYM_F: begin
        if (col == COL_I) begin
          hit = 1'b1;
          len = 1;
          s0 = SYM_I;
        end else if (col == COL_LP) begin
          hit = 1'b1;
          len = 3;
          s0 = SYM_LP;
          s1 = SYM_E;
          s2 = SYM_RP;
        end
      end
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic status_t advance_parse(input logic act, input logic [7:0] ch);
    col_t        col;
    sym_t        top;
    sym_t        s0, s1, s2;
    int          len;
    int unsigned base;
    bit          done;
    status_t     st;
    if (act == ACT_START) begin
      restart_stack();
      return ST_OK;
    end
    if (parse_phase != PH_PARSING) return ST_FINISHED;
    col = char_column(ch);
    done = 1'b0;
    st = ST_OK;
    while (!done) begin
      done = 1'b1;
      if (sym_count == 0 || sym_count > STACK_DEPTH) begin
        parse_phase = PH_REJECTED;
        st = ST_NO_ENTRY;
      end else begin
        top = sym_stack[sym_count - 1];
        if (top == SYM_END) begin
          parse_phase = (col == COL_END) ? PH_ACCEPTED : PH_REJECTED;
          st = (col == COL_END) ? ST_ACCEPT : ST_MISMATCH;
        end else if (top < SYM_E) begin
          if (top == sym_t'(col)) begin
            sym_count = sym_count - 1;
            st = ST_OK;
          end else begin
            parse_phase = PH_REJECTED;
            st = ST_MISMATCH;
          end
        end else if (!rule_for(top, col, len, s0, s1, s2)) begin
          parse_phase = PH_REJECTED;
          st = ST_NO_ENTRY;
        end else begin
          base = sym_count - 1;
          if (base + len > STACK_DEPTH) begin
            // expansion would not fit, stack left as it was
            parse_phase = PH_REJECTED;
            st = ST_OVERFLOW;
          end else begin
            // rightmost symbol goes deepest
            case (len)
              1: sym_stack[base] = s0;
              2: begin
                sym_stack[base] = s1;
                sym_stack[base + 1] = s0;
              end
              3: begin
                sym_stack[base] = s2;
                sym_stack[base + 1] = s1;
                sym_stack[base + 2] = s0;
              end
              default: ;
            endcase
            sym_count = base + len;
            done = 1'b0;
          end
        end
      end
    end
    return st;
  endfunction

  // append one predicted result at the tail of the queue
  function automatic void log_expected(input status_t st, input logic [6:0] dep);
    parse_result_t fresh;
    fresh.status = st;
    fresh.depth = dep;
    expected_results = {expected_results, fresh};
  endfunction

  function automatic void note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%0t ns: %s", $time, msg);
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      restart_stack();
      expected_results.delete();
      fail_count = 0;
      results_outstanding = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        step_status = advance_parse(in_tuser, in_tdata);
        log_expected(step_status, 7'(sym_count));
      end
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          note_failure($sformatf("unexpected result: status %0d depth %0d",
                                 out_tdata[2:0], out_tdata[9:3]));
        end else begin
          oldest = expected_results.pop_front();
          if (out_tdata[2:0] !== oldest.status || out_tdata[9:3] !== oldest.depth ||
              out_tdata[15:10] !== 6'd0)
            note_failure($sformatf(
              "result mismatch: expected status %0d depth %0d, got status %0d depth %0d pad %0h",
              oldest.status, oldest.depth, out_tdata[2:0], out_tdata[9:3],
              out_tdata[15:10]));
        end
      end
      results_outstanding = expected_results.size();
    end
  end

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import ll1ep_tb_pkg::*;

  localparam int HOLD_CYCLES   = 200;   // long receiver hold-off, fills the block
  localparam int IDLE_LIMIT    = 3000;  // cycles with no transaction before giving up
  localparam int PHASE_ITEMS   = 450;   // random items per idling phase
  localparam int SETTLE_CYCLES = 20;    // quiet time after the last result

  logic        clk = 1'b0;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;    // [7:0] char_code
  logic        in_tuser;    // [0] action
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;   // [2:0] status, [9:3] depth, [15:10] zero

  int check_failures;
  int results_pending;

  int send_idle_pct;        // chance per cycle that the sender stays idle
  int recv_stall_pct;       // chance per cycle that the receiver stalls
  logic hold_req = 1'b0;    // asks the receiver process for a long hold-off
  logic hold_done = 1'b0;   // receiver has served the hold-off
  int idle_cycles;
  int items_sent;

  // input transactions waiting to go out: {action, char_code}
  logic [8:0] stim_q [$];

  always #5 clk = ~clk;

  ll1_expression_parser_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  ll1_result_checker checker_i (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_tvalid          (in_tvalid),
    .in_tready          (in_tready),
    .in_tdata           (in_tdata),
    .in_tuser           (in_tuser),
    .out_tvalid         (out_tvalid),
    .out_tready         (out_tready),
    .out_tdata          (out_tdata),
    .fail_count         (check_failures),
    .results_outstanding(results_pending)
  );

  // receiver: random stalls, or one long hold-off counted here when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
      end
    end
  end

  // watchdog: too long without any transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic void push_item(input logic act, input logic [7:0] ch);
    logic [8:0] it;
    it = {act, ch};
    stim_q = {stim_q, it};
  endfunction

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(0, 5))
      0:       return CH_I;
      1:       return CH_PLUS;
      2:       return CH_STAR;
      3:       return CH_LP;
      4:       return CH_RP;
      default: return CH_END;
    endcase
  endfunction

  // half recognized characters, half any byte at all
  function automatic logic [7:0] pick_any_char();
    if ($urandom_range(0, 1) == 0) return pick_symbol();
    return 8'($urandom_range(0, 255));
  endfunction

  // well-formed expression text, nesting limited to keep runs short
  function automatic void gen_factor(input int lvl);
    if (lvl < 3 && $urandom_range(0, 99) < 20) begin
      push_item(ACT_CHAR, CH_LP);
      gen_expr(lvl + 1);
      push_item(ACT_CHAR, CH_RP);
    end else begin
      push_item(ACT_CHAR, CH_I);
    end
  endfunction

  function automatic void gen_term(input int lvl);
    int n;
    gen_factor(lvl);
    n = $urandom_range(0, 2);
    repeat (n) begin
      push_item(ACT_CHAR, CH_STAR);
      gen_factor(lvl);
    end
  endfunction

  function automatic void gen_expr(input int lvl);
    int n;
    gen_term(lvl);
    n = $urandom_range(0, 2);
    repeat (n) begin
      push_item(ACT_CHAR, CH_PLUS);
      gen_term(lvl);
    end
  endfunction

  // one random sequence: mostly complete parses, then nesting, corruption, noise and carry-on characters
  function automatic void build_sequence();
    int kind;
    int first;
    int k;
    kind = $urandom_range(0, 99);
    first = stim_q.size();
    if (kind < 55) begin
      push_item(ACT_START, 8'($urandom_range(0, 255)));
      gen_expr(0);
      push_item(ACT_CHAR, CH_END);
      // characters after the verdict
      k = $urandom_range(0, 2);
      repeat (k) push_item(ACT_CHAR, pick_symbol());
    end else if (kind < 65) begin
      // deep nesting, past the stack size for the larger counts
      push_item(ACT_START, 8'($urandom_range(0, 255)));
      k = $urandom_range(14, 24);
      repeat (k) push_item(ACT_CHAR, CH_LP);
      push_item(ACT_CHAR, CH_I);
      repeat (k) push_item(ACT_CHAR, CH_RP);
      push_item(ACT_CHAR, CH_END);
    end else if (kind < 80) begin
      // complete parse with one character replaced
      push_item(ACT_START, 8'($urandom_range(0, 255)));
      gen_expr(0);
      push_item(ACT_CHAR, CH_END);
      stim_q[$urandom_range(first + 1, stim_q.size() - 1)] = {ACT_CHAR, pick_any_char()};
    end else if (kind < 90) begin
      k = $urandom_range(1, 6);
      repeat (k) begin
        if ($urandom_range(0, 9) == 0) push_item(ACT_START, 8'($urandom_range(0, 255)));
        else push_item(ACT_CHAR, 8'($urandom_range(0, 255)));
      end
    end else begin
      // carry on from whatever state the last sequence left
      k = $urandom_range(1, 4);
      repeat (k) push_item(ACT_CHAR, pick_symbol());
    end
  endfunction

  function automatic int draw_gap(input int pct);
    int g;
    g = 0;
    while (g < 40 && $urandom_range(0, 99) < pct) g++;
    return g;
  endfunction

  // called right after a rising edge; returns right after the accepting edge
  task automatic send_item(input logic act, input logic [7:0] ch);
    int gap;
    gap = draw_gap(send_idle_pct);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= act;
    in_tdata <= ch;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_queued();
    logic [8:0] it;
    while (stim_q.size() > 0) begin
      it = stim_q.pop_front();
      send_item(it[8], it[7:0]);
    end
  endtask

  // sender stops offering until every predicted result has been seen
  task automatic wait_all_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tuser = ACT_START;
    in_tdata = 8'd0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    items_sent = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: parse straight out of reset, then accept, finished, no-entry and mismatch verdicts
    push_item(ACT_CHAR, CH_I);
    push_item(ACT_CHAR, CH_END);        // accepted
    push_item(ACT_CHAR, CH_I);          // already finished
    push_item(ACT_START, 8'hff);
    push_item(ACT_CHAR, 8'h00);         // invalid character, nonterminal on top
    push_item(ACT_CHAR, 8'hff);         // already finished after rejection
    push_item(ACT_START, 8'h00);
    push_item(ACT_CHAR, CH_I);
    push_item(ACT_CHAR, CH_RP);         // end marker meets ')'
    push_item(ACT_START, 8'h5a);
    push_item(ACT_CHAR, CH_LP);
    push_item(ACT_CHAR, CH_I);
    push_item(ACT_CHAR, CH_PLUS);
    push_item(ACT_CHAR, CH_I);
    push_item(ACT_CHAR, CH_STAR);
    push_item(ACT_CHAR, CH_I);
    push_item(ACT_CHAR, CH_RP);
    push_item(ACT_CHAR, CH_END);        // every terminal, accepted
    push_item(ACT_START, 8'h00);
    push_item(ACT_CHAR, CH_PLUS);       // no table entry
    push_item(ACT_START, 8'h00);
    push_item(ACT_CHAR, CH_LP);
    push_item(ACT_CHAR, CH_I);
    push_item(ACT_CHAR, CH_END);        // terminal ')' on top meets '$'
    send_queued();
    wait_all_results();

    // idling phases: none but one long receiver hold-off, sender idle, receiver stalling, both
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          hold_req <= 1'b1;     // long hold-off while the sender keeps going
        end
        1: begin
          send_idle_pct = 59;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 59;
        end
        default: begin
          send_idle_pct = 10;
          recv_stall_pct = 10;
        end
      endcase
      items_sent = 0;
      while (items_sent < PHASE_ITEMS) begin
        build_sequence();
        send_queued();
      end
      wait_all_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (check_failures == 0 && results_pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/ll1ep_pkg.sv
rtl/ll1_expression_parser_top.sv
tb/ll1ep_tb_pkg.sv
tb/ll1_result_checker.sv
tb/testbench.sv
